[rtl/complex_real_fir_filter_unit_macros.svh]
// Assertion helpers used by the checker file.
`ifndef COMPLEX_REAL_FIR_FILTER_UNIT_MACROS_SVH
`define COMPLEX_REAL_FIR_FILTER_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define CFRU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CFRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cfru_pkg.sv]
package cfru_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int TAP_BITS     = 16;
  localparam int TAP_FRAC     = 15;
  localparam int TC_BITS      = 6;
  localparam int TAP_IDX_BITS = 5;

  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  localparam logic [TC_BITS-1:0] TAP_COUNT_RESET = 6'd16;

  typedef logic signed [TAP_BITS-1:0] tap_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] i;
    logic signed [SAMPLE_BITS-1:0] q;
  } cplx_t;

  typedef struct packed {
    logic                          opcode;
    logic signed [SAMPLE_BITS-1:0] sample_i;
    logic signed [SAMPLE_BITS-1:0] sample_q;
    logic [TAP_IDX_BITS-1:0]       tap_index;
    logic signed [TAP_BITS-1:0]    tap_value;
    logic                          end_of_block;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_i;
    logic signed [SAMPLE_BITS-1:0] out_q;
    logic                          block_end;
  } out_item_t;

  // Controls broadcast from the sequencer to every cell of the line.
  typedef struct packed {
    logic hist_shift;
    logic work_load;
    logic work_shift;
    logic tap_rot;
  } cell_ctrl_t;

endpackage

[rtl/cfru_cell.sv]
module cfru_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  cfru_pkg::cell_ctrl_t ctrl,
  input  logic               tap_wr,
  input  cfru_pkg::tap_t     tap_wdata,
  input  cfru_pkg::cplx_t    hist_in,
  output cfru_pkg::cplx_t    hist_out,
  input  cfru_pkg::cplx_t    work_in,
  output cfru_pkg::cplx_t    work_out,
  input  cfru_pkg::tap_t     tap_in,
  output cfru_pkg::tap_t     tap_out
);
  import cfru_pkg::*;

  cplx_t hist_r;
  cplx_t work_r;
  tap_t  tap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else if (ctrl.hist_shift) begin
      hist_r <= hist_in;
    end
  end

  // Working copy of the history that walks toward the read point while a sum runs.
  always_ff @(posedge clk) begin
    if (ctrl.work_load) begin
      work_r <= hist_r;
    end else if (ctrl.work_shift) begin
      work_r <= work_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= '0;
    end else if (tap_wr) begin
      tap_r <= tap_wdata;
    end else if (ctrl.tap_rot) begin
      tap_r <= tap_in;
    end
  end

  assign hist_out = hist_r;
  assign work_out = work_r;
  assign tap_out  = tap_r;

endmodule

[rtl/cfru_mac.sv]
module cfru_mac #(
  parameter int MAX_TAPS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            clear,
  input  logic            feed,
  input  cfru_pkg::tap_t  tap,
  input  cfru_pkg::cplx_t smp,
  output cfru_pkg::cplx_t res
);
  import cfru_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + TAP_BITS;
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;
  localparam int QW     = ACC_W - TAP_FRAC;

  localparam logic signed [ACC_W-1:0] RND_C  = ACC_W'(1) << (TAP_FRAC - 1);
  localparam logic signed [QW-1:0]    SAT_HI = QW'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic signed [QW-1:0]    SAT_LO = QW'(-(2 ** (SAMPLE_BITS - 1)));

  logic                     prod_vld_r;
  logic signed [PROD_W-1:0] prod_i_r;
  logic signed [PROD_W-1:0] prod_q_r;
  logic signed [ACC_W-1:0]  acc_i_r;
  logic signed [ACC_W-1:0]  acc_q_r;

  // Round half up, floor shift, then clamp to the sample range.
  function automatic logic signed [SAMPLE_BITS-1:0] finish(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W-1:0] r;
    logic signed [QW-1:0]    q;
    r = acc + RND_C;
    q = QW'(r >>> TAP_FRAC);
    if (q > SAT_HI) begin
      return SAMPLE_BITS'(SAT_HI);
    end else if (q < SAT_LO) begin
      return SAMPLE_BITS'(SAT_LO);
    end
    return SAMPLE_BITS'(q);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= feed;
    end
  end

  always_ff @(posedge clk) begin
    prod_i_r <= tap * smp.i;
    prod_q_r <= tap * smp.q;
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      acc_i_r <= '0;
      acc_q_r <= '0;
    end else if (prod_vld_r) begin
      acc_i_r <= acc_i_r + ACC_W'(prod_i_r);
      acc_q_r <= acc_q_r + ACC_W'(prod_q_r);
    end
  end

  assign res.i = finish(acc_i_r);
  assign res.q = finish(acc_q_r);

endmodule

[rtl/complex_real_fir_filter_unit.sv]
// A sample request keeps the block busy (in_stall high) from acceptance until its
// result is written to the output register, and longer while an earlier result is
// stalled; a tap load leaves the block free. The sample time is set by the tap line,
// rotating once through all MAX_TAPS cells past the single multiply-accumulate unit.
// Reset (rst_n low, synchronous) clears the history and all taps, sets tap_count to 16
// and empties the output register.
module complex_real_fir_filter_unit #(
  parameter int MAX_TAPS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  cfru_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output cfru_pkg::out_item_t          out_data,
  input  logic                         cfg_we,
  input  logic [cfru_pkg::TC_BITS-1:0] cfg_wdata
);
  import cfru_pkg::*;

  localparam int IDX_W = $clog2(MAX_TAPS);
  localparam int CNT_W = $clog2(MAX_TAPS + 2);
  localparam logic [CNT_W-1:0]   CNT_LAST = CNT_W'(MAX_TAPS + 1);
  localparam logic [CNT_W-1:0]   CNT_ROT  = CNT_W'(MAX_TAPS);
  localparam logic [TC_BITS:0]   TC_MAX   = (TC_BITS + 1)'(MAX_TAPS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [TC_BITS-1:0] tap_count_r;
  logic [IDX_W-1:0]   len_m1_r, len_m1_nxt;
  logic               eob_r;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r;

  logic       in_acc;
  logic       filt_acc;
  logic       load_acc;
  logic       out_free;
  logic [TC_BITS:0] tc_ext;
  cell_ctrl_t ctrl;
  cplx_t      new_smp;
  cplx_t      mac_res;

  cplx_t hist_o [MAX_TAPS];
  cplx_t work_o [MAX_TAPS];
  tap_t  tap_o  [MAX_TAPS];

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign filt_acc = in_acc && (in_data.opcode == OP_FILTER);
  assign load_acc = in_acc && (in_data.opcode == OP_LOAD);
  assign out_free = !out_valid_r || !out_stall;

  assign new_smp.i = in_data.sample_i;
  assign new_smp.q = in_data.sample_q;

  assign ctrl.hist_shift = filt_acc;
  assign ctrl.work_load  = (state_r == ST_LOAD);
  assign ctrl.work_shift = (state_r == ST_RUN);
  assign ctrl.tap_rot    = (state_r == ST_RUN) && (cnt_r < CNT_ROT);

  genvar k;
  generate
    for (k = 0; k < MAX_TAPS; k++) begin : g_cell
      cplx_t hist_in_w;
      cplx_t work_in_w;
      tap_t  tap_in_w;
      logic  tap_wr_w;

      if (k == 0) begin : g_head
        assign hist_in_w = new_smp;
        assign work_in_w = '0;
      end else begin : g_body
        assign hist_in_w = hist_o[k-1];
        assign work_in_w = work_o[k-1];
      end

      // Taps move toward cell 0 and wrap, so cell 0 presents tap k on step k.
      if (k == MAX_TAPS - 1) begin : g_wrap
        assign tap_in_w = tap_o[0];
      end else begin : g_next
        assign tap_in_w = tap_o[k+1];
      end

      assign tap_wr_w = load_acc && (int'(in_data.tap_index) == k);

      cfru_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .tap_wr    (tap_wr_w),
        .tap_wdata (in_data.tap_value),
        .hist_in   (hist_in_w),
        .hist_out  (hist_o[k]),
        .work_in   (work_in_w),
        .work_out  (work_o[k]),
        .tap_in    (tap_in_w),
        .tap_out   (tap_o[k])
      );
    end
  endgenerate

  // The working line shifts up by one each step, so the cell at the last tap in use
  // shows the history from the oldest sample in the window toward the newest.
  cfru_mac #(
    .MAX_TAPS (MAX_TAPS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (state_r == ST_LOAD),
    .feed  ((state_r == ST_RUN) && (cnt_r <= CNT_W'(len_m1_r))),
    .tap   (tap_o[0]),
    .smp   (work_o[len_m1_r]),
    .res   (mac_res)
  );

  assign tc_ext = {1'b0, tap_count_r};

  always_comb begin
    if (tc_ext == '0) begin
      len_m1_nxt = '0;
    end else if (tc_ext > TC_MAX) begin
      len_m1_nxt = IDX_W'(MAX_TAPS - 1);
    end else begin
      len_m1_nxt = IDX_W'(tc_ext - 1'b1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (filt_acc) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_RUN;
        cnt_nxt   = '0;
      end
      ST_RUN: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if ((state_r == ST_DONE) && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      tap_count_r <= TAP_COUNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tap_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) begin
      len_m1_r <= len_m1_nxt;
    end
    if (filt_acc) begin
      eob_r <= in_data.end_of_block;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_data_r.out_i     <= mac_res.i;
      out_data_r.out_q     <= mac_res.q;
      out_data_r.block_end <= eob_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/cfru_checker.sv]
`include "complex_real_fir_filter_unit_macros.svh"

module cfru_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input cfru_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input cfru_pkg::out_item_t out_data
);
  import cfru_pkg::*;

  // A stalled result stays offered unchanged.
  `CFRU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // A sample request keeps the block busy while its sum is formed.
  `CFRU_ASSERT_NEXT(a_filter_busy, in_valid && !in_stall && (in_data.opcode == OP_FILTER), in_stall, "block free right after a sample request")

  // A tap load leaves the block free for the next request.
  `CFRU_ASSERT_NEXT(a_load_free, in_valid && !in_stall && (in_data.opcode == OP_LOAD), !in_stall, "block busy after a tap load")

  // A new result only appears at the end of a busy period.
  `CFRU_ASSERT_SAME(a_out_from_busy, $rose(out_valid), $past(in_stall), "result appeared without a sample in work")

endmodule

bind complex_real_fir_filter_unit cfru_checker u_cfru_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[sim/tb_complex_real_fir_filter_unit.sv]
module tb_complex_real_fir_filter_unit;
  import cfru_pkg::*;

  localparam int MAX_TAPS = 32;
  localparam int LIMIT_CYCLES = 1500000;
  localparam int PHASE_ITEMS = 112;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [TC_BITS-1:0] cfg_wdata = '0;

  complex_real_fir_filter_unit #(
    .MAX_TAPS(MAX_TAPS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Filter model state, kept in step with the accepted requests.
  cplx_t hist_model [MAX_TAPS];
  tap_t tap_model [MAX_TAPS];
  logic [TC_BITS-1:0] tap_count_model = TAP_COUNT_RESET;

  in_item_t pending_reqs [$];
  out_item_t awaited_outputs [$];
  int reqs_in_flight = 0;
  int err_count = 0;

  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int stall_hold = 0;
  out_item_t want_out;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    foreach (hist_model[k]) hist_model[k] = '0;
    foreach (tap_model[k]) tap_model[k] = '0;
  end

  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(longint acc);
    longint r;
    r = (acc + (longint'(1) << (TAP_FRAC - 1))) >>> TAP_FRAC;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[SAMPLE_BITS-1:0];
  endfunction

  function automatic out_item_t filter_sample(in_item_t req);
    int used;
    longint acc_i;
    longint acc_q;
    out_item_t res;
    for (int k = MAX_TAPS - 1; k > 0; k--) hist_model[k] = hist_model[k-1];
    hist_model[0].i = req.sample_i;
    hist_model[0].q = req.sample_q;
    used = tap_count_model;
    if (used < 1) used = 1;
    if (used > MAX_TAPS) used = MAX_TAPS;
    acc_i = 0;
    acc_q = 0;
    // Tap 0 weights the oldest of the samples in use.
    for (int k = 0; k < used; k++) begin
      acc_i += longint'($signed(tap_model[k])) * longint'($signed(hist_model[used-1-k].i));
      acc_q += longint'($signed(tap_model[k])) * longint'($signed(hist_model[used-1-k].q));
    end
    res.out_i = round_sat(acc_i);
    res.out_q = round_sat(acc_q);
    res.block_end = req.end_of_block;
    return res;
  endfunction

  task automatic absorb_request(in_item_t req);
    if (req.opcode == OP_LOAD) begin
      if (req.tap_index < MAX_TAPS) tap_model[req.tap_index] = req.tap_value;
    end else begin
      awaited_outputs.push_back(filter_sample(req));
    end
  endtask

  task automatic flag_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    err_count++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %h, want %h", name, got, want));
  endtask

  function automatic logic [15:0] rand_q15();
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0: v = 16'h7FFF;
      1: v = 16'h8000;
      2: v = 16'($urandom_range(0, 15) - 8);
      default: v = 16'($urandom());
    endcase
    return v;
  endfunction

  task automatic queue_sample(logic [15:0] si, logic [15:0] sq, logic eob);
    in_item_t req;
    req.opcode = OP_FILTER;
    req.sample_i = si;
    req.sample_q = sq;
    req.tap_index = TAP_IDX_BITS'($urandom());
    req.tap_value = TAP_BITS'($urandom());
    req.end_of_block = eob;
    pending_reqs.push_back(req);
    reqs_in_flight++;
  endtask

  task automatic queue_load(int idx, logic [15:0] val);
    in_item_t req;
    req.opcode = OP_LOAD;
    req.sample_i = SAMPLE_BITS'($urandom());
    req.sample_q = SAMPLE_BITS'($urandom());
    req.tap_index = TAP_IDX_BITS'(idx);
    req.tap_value = val;
    req.end_of_block = 1'($urandom_range(0, 1));
    pending_reqs.push_back(req);
    reqs_in_flight++;
  endtask

  // Waits until every request is through and the last one has had time to finish.
  task automatic settle();
    while (reqs_in_flight != 0 || awaited_outputs.size() != 0) @(posedge clk);
    repeat (MAX_TAPS + 8) @(posedge clk);
  endtask

  task automatic set_tap_count(logic [TC_BITS-1:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    tap_count_model = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_items(int n);
    int left;
    int pick;
    left = n;
    while (left > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        // A full reload of the tap store followed by whatever comes next.
        for (int k = 0; k < MAX_TAPS; k++) queue_load(k, rand_q15());
        left -= MAX_TAPS;
      end else if (pick < 25) begin
        queue_load($urandom_range(0, MAX_TAPS - 1), rand_q15());
        left--;
      end else begin
        queue_sample(rand_q15(), rand_q15(), 1'($urandom_range(0, 1)));
        left--;
      end
    end
  endtask

  // Sender: bursts of requests with random gaps; a stalled request is held.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_request(in_data);
        reqs_in_flight--;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
          if (burst_left != 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 50);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: the stall pattern switches at random among four modes.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_hold = 0;
      mode_left = 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      if (stall_hold != 0) begin
        stall_hold--;
      end else begin
        case (stall_mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= 1'($urandom_range(0, 1));
          end
          2: begin
            if ($urandom_range(0, 7) == 0) begin
              out_stall <= 1'b1;
              stall_hold = $urandom_range(5, 60);
            end else begin
              out_stall <= 1'b0;
            end
          end
          default: begin
            out_stall <= ($urandom_range(0, 3) != 0);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_outputs.size() == 0) begin
        flag_mismatch("result with no sample request waiting");
      end else begin
        want_out = awaited_outputs.pop_front();
        check_field("out_i", out_data.out_i, want_out.out_i);
        check_field("out_q", out_data.out_q, want_out.out_q);
        check_field("block_end", {15'd0, out_data.block_end}, {15'd0, want_out.block_end});
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset tap count with an empty tap store: the first output must be zero.
    queue_sample(16'h7FFF, 16'h8000, 1'b1);
    queue_load(0, 16'h7FFF);
    queue_load(15, 16'h8000);
    queue_load(31, 16'h3039);
    queue_sample(16'h7FFF, 16'h7FFF, 1'b0);
    queue_sample(16'h8000, 16'h8000, 1'b1);
    queue_sample(16'h0001, 16'hFFFF, 1'b0);
    repeat (7) queue_sample(rand_q15(), rand_q15(), 1'($urandom_range(0, 1)));

    // One tap: half-way rounding goes up, and the most negative square saturates.
    set_tap_count(6'd1);
    queue_load(0, 16'h4000);
    queue_sample(16'h0001, 16'hFFFF, 1'b0);
    queue_sample(16'h7FFF, 16'h8000, 1'b1);
    queue_load(0, 16'h8000);
    queue_sample(16'h8000, 16'h7FFF, 1'b0);
    queue_sample(16'h7FFF, 16'h8000, 1'b1);

    // Two full-scale negative taps drive out_i to negative and out_q to positive saturation.
    set_tap_count(6'd2);
    queue_load(1, 16'h8000);
    queue_sample(16'h7FFF, 16'h8000, 1'b0);
    queue_sample(16'h7FFF, 16'h8000, 1'b1);

    set_tap_count(6'd32);
    random_items(PHASE_ITEMS);
    set_tap_count(6'd0);
    random_items(PHASE_ITEMS);
    set_tap_count(6'd63);
    random_items(PHASE_ITEMS);
    set_tap_count(6'd33);
    random_items(PHASE_ITEMS);
    set_tap_count(6'd2);
    random_items(PHASE_ITEMS);
    set_tap_count(TAP_COUNT_RESET);
    random_items(PHASE_ITEMS);
    set_tap_count(TC_BITS'($urandom_range(3, 31)));
    random_items(PHASE_ITEMS);
    set_tap_count(6'd1);
    random_items(PHASE_ITEMS);
    set_tap_count(TC_BITS'($urandom_range(0, 63)));
    random_items(PHASE_ITEMS);
    set_tap_count(6'd32);
    random_items(PHASE_ITEMS);

    settle();
    if (err_count == 0) begin
      $display("tb_complex_real_fir_filter_unit: clean");
    end else begin
      $display("tb_complex_real_fir_filter_unit: errors");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 10);
    $display("tb_complex_real_fir_filter_unit: errors");
    $finish;
  end

endmodule
